// File: sv/four_channel_echo_ranger_core_assert.svh
// Assertion macros for the echo ranger RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef FOUR_CHANNEL_ECHO_RANGER_CORE_ASSERT_SVH
`define FOUR_CHANNEL_ECHO_RANGER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define ERC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ERC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/erc_pkg.sv
// Package for the four-channel echo ranger: item types, control structs,
// register codes and conversion constants. No dependencies.
`default_nettype none

package erc_pkg;

    // field widths
    localparam int unsigned POS_W      = 7;
    localparam int unsigned DIST_W     = 13;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned UPT_W      = 5;
    localparam int unsigned OFS_W      = 8;
    localparam int unsigned LEVELS_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // reported channels and their index width
    localparam int unsigned OUT_CH = 4;
    localparam int unsigned CH_W   = 2;

    // parameter defaults
    localparam int unsigned CHANNELS_DEF    = 4;
    localparam int unsigned COUNT_BITS_DEF  = 16;
    localparam int unsigned SWEEP_LIMIT_DEF = 90;

    // register reset values
    localparam logic [SPEED_W-1:0] SPEED_RST = 16'd34853;
    localparam logic [UPT_W-1:0]   UPT_RST   = 5'd4;
    localparam logic [OFS_W-1:0]   OFS_A_RST = 8'd8;
    localparam logic [OFS_W-1:0]   OFS_B_RST = 8'd8;
    localparam logic [OFS_W-1:0]   OFS_C_RST = 8'd8;
    localparam logic [OFS_W-1:0]   OFS_D_RST = 8'd7;

    // divide by 2000000 = 2^7 * 15625; quotient over 8191 saturates anyway,
    // so the shifted product is clamped to 27 bits before the reciprocal step
    localparam int unsigned DIV_SHIFT = 7;
    localparam int unsigned QY_W      = 27;
    localparam int unsigned Q_W       = 14;
    localparam logic [Q_W-1:0]  DIV_ODD  = 14'd15625;
    localparam logic [Q_W-1:0]  RECIP_M  = 14'd8589;  // floor(2^27 / 15625)
    localparam logic [QY_W-1:0] QY_MAX   = {QY_W{1'b1}};
    localparam logic [DIST_W:0] DIST_MAX = 14'd8191;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED = 3'd0,
        REG_UPT   = 3'd1,
        REG_OFS_A = 3'd2,
        REG_OFS_B = 3'd3,
        REG_OFS_C = 3'd4,
        REG_OFS_D = 3'd5
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic                command;
        logic [LEVELS_W-1:0] echo_levels;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [DIST_W-1:0] distance_a;
        logic [DIST_W-1:0] distance_b;
        logic [DIST_W-1:0] distance_c;
        logic [DIST_W-1:0] distance_d;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic            arm;
        logic            tick;
        logic            mul_a;
        logic            mul_b;
        logic            recip;
        logic            back;
        logic            fix;
        logic            load_out;
        logic [CH_W-1:0] ch;
    } erc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_done;
    } erc_status_t;

endpackage

`default_nettype wire

// File: sv/erc_datapath.sv
// Datapath of the echo ranger: configuration registers, per-channel pulse
// counters, distance conversion unit, sweep position and result register.
// Depends on erc_pkg.
`default_nettype none

module erc_datapath #(
    parameter int unsigned CHANNELS    = erc_pkg::CHANNELS_DEF,
    parameter int unsigned COUNT_BITS  = erc_pkg::COUNT_BITS_DEF,
    parameter int unsigned SWEEP_LIMIT = erc_pkg::SWEEP_LIMIT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire erc_pkg::in_item_t               in_item,
    input  wire erc_pkg::erc_cmd_t               cmd,
    output erc_pkg::erc_status_t                 status,
    output erc_pkg::out_item_t                   out_item
);
    import erc_pkg::*;

    localparam int unsigned NUM_CONV = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int unsigned P1_W     = COUNT_BITS + UPT_W;
    localparam int unsigned P2_W     = P1_W + SPEED_W;
    localparam int unsigned Y_W      = P2_W - DIV_SHIFT;
    localparam int unsigned PROD_W   = QY_W + Q_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [POS_W-1:0]      POS_LIMIT = POS_W'(SWEEP_LIMIT);

    // per-channel phase codes
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ARMED = 4'b0010,
        PH_COUNT = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    // configuration
    logic [SPEED_W-1:0] speed_reg;
    logic [UPT_W-1:0]   upt_reg;
    logic [OFS_W-1:0]   ofs_reg [OUT_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RST;
            upt_reg    <= UPT_RST;
            ofs_reg[0] <= OFS_A_RST;
            ofs_reg[1] <= OFS_B_RST;
            ofs_reg[2] <= OFS_C_RST;
            ofs_reg[3] <= OFS_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SPEED: speed_reg  <= cfg_data;
                REG_UPT:   upt_reg    <= cfg_data[UPT_W-1:0];
                REG_OFS_A: ofs_reg[0] <= cfg_data[OFS_W-1:0];
                REG_OFS_B: ofs_reg[1] <= cfg_data[OFS_W-1:0];
                REG_OFS_C: ofs_reg[2] <= cfg_data[OFS_W-1:0];
                REG_OFS_D: ofs_reg[3] <= cfg_data[OFS_W-1:0];
                default:   ;
            endcase
        end
    end

    // channel phase and pulse counters
    phase_t                phase_reg  [CHANNELS];
    phase_t                phase_next [CHANNELS];
    logic [COUNT_BITS-1:0] ticks_reg  [CHANNELS];
    logic [COUNT_BITS-1:0] ticks_next [CHANNELS];
    logic                  finished;
    logic                  all_done;

    always_comb
    begin
        finished = 1'b0;
        all_done = 1'b1;
        for (int k = 0; k < CHANNELS; k++)
        begin
            logic high;
            high          = (k < LEVELS_W) ? in_item.echo_levels[k % LEVELS_W] : 1'b0;
            phase_next[k] = phase_reg[k];
            ticks_next[k] = ticks_reg[k];
            case (phase_reg[k])
                PH_ARMED:
                begin
                    if (high)
                    begin
                        phase_next[k] = PH_COUNT;
                        ticks_next[k] = COUNT_BITS'(1);
                    end
                end
                PH_COUNT:
                begin
                    if (high)
                    begin
                        if (ticks_reg[k] != COUNT_MAX)
                            ticks_next[k] = ticks_reg[k] + COUNT_BITS'(1);
                    end
                    else
                    begin
                        phase_next[k] = PH_DONE;
                        finished      = 1'b1;
                    end
                end
                default: ;
            endcase
            if (phase_next[k] != PH_DONE)
                all_done = 1'b0;
        end
    end

    assign status.frame_done = finished && all_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                phase_reg[k] <= PH_IDLE;
                ticks_reg[k] <= '0;
            end
        end
        else if (cmd.arm)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                phase_reg[k] <= PH_ARMED;
                ticks_reg[k] <= '0;
            end
        end
        else if (cmd.tick)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                phase_reg[k] <= status.frame_done ? PH_IDLE : phase_next[k];
                ticks_reg[k] <= ticks_next[k];
            end
        end
    end

    // count of the channel under conversion
    logic [COUNT_BITS-1:0] sel_ticks;

    always_comb
    begin
        sel_ticks = '0;
        for (int k = 0; k < NUM_CONV; k++)
        begin
            if (cmd.ch == CH_W'(k))
                sel_ticks = ticks_reg[k];
        end
    end

    // conversion unit: one step per cycle, one channel at a time
    logic [P1_W-1:0]   p1_reg;
    logic [P2_W-1:0]   p2_reg;
    logic [QY_W-1:0]   y_reg;
    logic [Q_W-1:0]    qe_reg;
    logic [2*Q_W-1:0]  back_reg;
    logic [DIST_W-1:0] dist_reg [OUT_CH];

    logic [Y_W-1:0]    y_full;
    logic [QY_W-1:0]   y_sat;
    logic [PROD_W-1:0] recip_prod;
    logic [QY_W-1:0]   rem;
    logic [Q_W-1:0]    q_fix;
    logic [DIST_W:0]   dist_sum;
    logic [DIST_W-1:0] dist_val;

    // clamp the shifted product: anything past 27 bits saturates the distance
    assign y_full     = p2_reg[P2_W-1:DIV_SHIFT];
    assign y_sat      = (|(y_full >> QY_W)) ? QY_MAX : QY_W'(y_full);
    assign recip_prod = PROD_W'(y_sat) * PROD_W'(RECIP_M);

    // estimate is low by at most one
    assign rem      = y_reg - QY_W'(back_reg);
    assign q_fix    = qe_reg + Q_W'(rem >= QY_W'(DIV_ODD));
    assign dist_sum = (DIST_W+1)'(q_fix) + (DIST_W+1)'(ofs_reg[cmd.ch]);
    assign dist_val = (dist_sum > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
                                            : dist_sum[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
            p1_reg <= P1_W'(sel_ticks) * P1_W'(upt_reg);
        if (cmd.mul_b)
            p2_reg <= P2_W'(p1_reg) * P2_W'(speed_reg);
        if (cmd.recip)
        begin
            y_reg  <= y_sat;
            qe_reg <= recip_prod[PROD_W-1:QY_W];
        end
        if (cmd.back)
            back_reg <= (2*Q_W)'(qe_reg) * (2*Q_W)'(DIV_ODD);
        if (cmd.fix)
            dist_reg[cmd.ch] <= dist_val;
    end

    // sweep position, triangle 0..SWEEP_LIMIT..0
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             down_reg;
    logic             down_next;
    logic [POS_W-1:0] pos_dec;

    always_comb
    begin
        pos_dec   = (pos_reg != '0) ? pos_reg - POS_W'(1) : '0;
        pos_next  = pos_reg;
        down_next = down_reg;
        if (!down_reg)
        begin
            if (pos_reg + POS_W'(1) >= POS_LIMIT)
            begin
                pos_next  = POS_LIMIT;
                down_next = 1'b1;
            end
            else
                pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next  = pos_dec;
            down_next = (pos_dec != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            down_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            pos_reg  <= pos_next;
            down_reg <= down_next;
        end
    end

    // result register; unreported channels read as zero
    logic [DIST_W-1:0] dist_out [OUT_CH];
    out_item_t         out_reg;

    always_comb
    begin
        for (int k = 0; k < OUT_CH; k++)
            dist_out[k] = (k < CHANNELS) ? dist_reg[k] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.position   <= pos_reg;
            out_reg.distance_a <= dist_out[0];
            out_reg.distance_b <= dist_out[1];
            out_reg.distance_c <= dist_out[2];
            out_reg.distance_d <= dist_out[3];
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// File: sv/erc_ctrl.sv
// Controller of the echo ranger: input and output handshakes and the
// per-channel conversion sequence. Depends on erc_pkg and the assert header.
`default_nettype none
`include "four_channel_echo_ranger_core_assert.svh"

module erc_ctrl #(
    parameter int unsigned CHANNELS = erc_pkg::CHANNELS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_command,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire erc_pkg::erc_status_t status,
    output erc_pkg::erc_cmd_t         cmd
);
    import erc_pkg::*;

    localparam int unsigned NUM_CONV = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CONV - 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL_A = 7'b0000010,
        ST_MUL_B = 7'b0000100,
        ST_RECIP = 7'b0001000,
        ST_BACK  = 7'b0010000,
        ST_FIX   = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } ctl_state_t;

    ctl_state_t      state_reg;
    ctl_state_t      state_next;
    logic [CH_W-1:0] ch_reg;
    logic [CH_W-1:0] ch_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.ch         = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command)
                        cmd.arm = 1'b1;
                    else
                    begin
                        cmd.tick = 1'b1;
                        if (status.frame_done)
                        begin
                            state_next = ST_MUL_A;
                            ch_next    = '0;
                        end
                    end
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK:
            begin
                cmd.back   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
                if (ch_reg == LAST_CH)
                    state_next = ST_LOAD;
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_MUL_A;
                end
            end
            ST_LOAD:
            begin
                // wait for the result register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a completed frame starts conversion at the first channel
    `ERC_ASSERT_NEXT(a_frame_start, cmd.tick && status.frame_done, state_reg == ST_MUL_A && ch_reg == '0, "conversion did not start at channel zero")
    // the last channel's fix step leads to the result load
    `ERC_ASSERT_NEXT(a_last_fix, state_reg == ST_FIX && ch_reg == LAST_CH, state_reg == ST_LOAD, "conversion did not end after the last channel")
    // loading a result always leaves it valid
    `ERC_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid && state_reg == ST_IDLE, "loaded result not presented")
    // no item is taken while a conversion is under way
    `ERC_ASSERT_SAME(a_no_accept_busy, state_reg != ST_IDLE, !in_ready && !cmd.tick && !cmd.arm, "item accepted during conversion")

endmodule

`default_nettype wire

// File: sv/four_channel_echo_ranger_core.sv
// Four-channel echo ranger: arm and tick items drive per-channel pulse counters.
// Arm and tick items are taken one per cycle while the controller is idle. The tick
// that ends a frame runs, for each reported channel in turn, the multiply, second
// multiply, reciprocal, back and fix steps on the shared conversion unit, then the
// result register load, held while the previous result waits; no item is taken meanwhile.
// Async active-low reset: channels idle, counts zero, sweep 0 going up, defaults, no result.
`default_nettype none

module four_channel_echo_ranger_core #(
    parameter int unsigned CHANNELS    = erc_pkg::CHANNELS_DEF,
    parameter int unsigned COUNT_BITS  = erc_pkg::COUNT_BITS_DEF,
    parameter int unsigned SWEEP_LIMIT = erc_pkg::SWEEP_LIMIT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire erc_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output erc_pkg::out_item_t                  out_item
);
    import erc_pkg::*;

    erc_cmd_t    cmd;
    erc_status_t status;

    // sequencing and handshakes
    erc_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_item.command),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // counters, conversion, sweep and result register
    erc_datapath #(
        .CHANNELS    (CHANNELS),
        .COUNT_BITS  (COUNT_BITS),
        .SWEEP_LIMIT (SWEEP_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
